### rtl/core/lehmer_rng_ranged_defines.svh
// ----------------------------------------------------------------------------
// Lehmer generator assertion macros
// Shared concurrent assertion forms for the ranged Lehmer random source.
// ----------------------------------------------------------------------------
`ifndef LEHMER_RNG_RANGED_DEFINES_SVH
`define LEHMER_RNG_RANGED_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define LRR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define LRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/lrr_pkg.sv
// ----------------------------------------------------------------------------
// lrr_pkg
// Types and constants shared by the ranged Lehmer random source.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrr_pkg;

    // Request codes
    localparam logic [1:0] CMD_RAW   = 2'd0;
    localparam logic [1:0] CMD_RANGE = 2'd1;
    localparam logic [1:0] CMD_BOOL  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // Generator constants
    localparam int unsigned STATE_W    = 31;
    localparam int unsigned REM_W      = 32;
    localparam int unsigned REM_CNT_W  = $clog2(REM_W);
    localparam logic [15:0] LEHMER_MUL = 16'd48271;

    // Ranged request constants
    localparam int unsigned SMALL_SPAN_BITS = 20;
    localparam logic [31:0] BOOL_LOW        = 32'd1;
    localparam logic [31:0] BOOL_HIGH       = 32'd100;
    localparam logic [31:0] BOOL_CUT        = 32'd50;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FOLD,
        S_SETUP,
        S_MUL,
        S_STEP,
        S_MOD,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        M_FULL,
        M_SMALL,
        M_MASK
    } t_mode;

    typedef struct packed {
        logic             start;
        logic [REM_W-1:0] dividend;
        logic [REM_W-1:0] divisor;
    } t_rem_req;

    typedef struct packed {
        logic             done;
        logic [REM_W-1:0] rem;
    } t_rem_rsp;

endpackage

### rtl/core/lrr_step.sv
// ----------------------------------------------------------------------------
// lrr_step
// One Lehmer advance x -> 48271*x mod (2^31-1): split 16-bit products are
// registered, then folded end-around into the next state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrr_step
    import lrr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_load,
    input  logic [STATE_W-1:0] i_x,
    output logic [STATE_W-1:0] o_next
);

    logic [30:0] r_hi_prod;
    logic [31:0] r_lo_prod;
    logic [30:0] hi_sum;
    logic [30:0] lo_part;
    logic [31:0] fold_sum;

    // Register both partial products of the current state
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hi_prod <= {16'd0, i_x[30:16]} * {15'd0, LEHMER_MUL};
            r_lo_prod <= {16'd0, i_x[15:0]} * {16'd0, LEHMER_MUL};
        end
    end

    // Combine the halves and fold bit 31 back in
    always_comb begin
        hi_sum   = r_hi_prod + 31'(r_lo_prod[31:16]);
        lo_part  = {hi_sum[14:0], r_lo_prod[15:0]};
        fold_sum = {1'b0, lo_part} + 32'(hi_sum[30:15]);
        if (fold_sum[31]) begin
            o_next = fold_sum[30:0] + 31'd1;
        end else begin
            o_next = fold_sum[30:0];
        end
    end

endmodule

### rtl/core/lrr_rem_unit.sv
// ----------------------------------------------------------------------------
// lrr_rem_unit
// Restoring remainder unit: one dividend bit per cycle, all 32 bits per start.
// A new start restarts it at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lehmer_rng_ranged_defines.svh"

module lrr_rem_unit
    import lrr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rem_req i_req,
    output t_rem_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [REM_CNT_W-1:0] r_count;
    logic [REM_W-1:0]     r_rem;
    logic [REM_W-1:0]     r_dvd;
    logic [REM_W-1:0]     r_divisor;

    logic [REM_W:0]       trial;
    logic [REM_W:0]       diff;
    logic [REM_W-1:0]     n_rem;

    // Shift in the next dividend bit and subtract when it fits
    always_comb begin
        trial = {r_rem, r_dvd[REM_W-1]};
        diff  = trial - {1'b0, r_divisor};
        if (trial >= {1'b0, r_divisor}) begin
            n_rem = diff[REM_W-1:0];
        end else begin
            n_rem = trial[REM_W-1:0];
        end
    end

    // Sequence the iterations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else if (i_req.start) begin
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
            r_count <= '0;
        end else if (r_busy) begin
            r_count <= r_count + 1'b1;
            if (r_count == REM_CNT_W'(REM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= '0;
            r_dvd     <= i_req.dividend;
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[REM_W-2:0], 1'b0};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

    `LRR_ASSERT_NOW(a_rem_below_divisor, i_clk, i_rst_n, r_done, r_rem < r_divisor, "remainder not below divisor")
    `LRR_ASSERT_NOW(a_done_after_busy, i_clk, i_rst_n, r_done, $past(r_busy), "done without a run")
    `LRR_ASSERT_NOW(a_busy_done_excl, i_clk, i_rst_n, r_busy, !r_done, "busy and done together")

endmodule

### rtl/core/lehmer_rng_ranged.sv
// ----------------------------------------------------------------------------
// lehmer_rng_ranged
// Lehmer random source (multiplier 48271, modulus 2^31-1) with raw, ranged
// and boolean requests, driven by a small sequencer over a shared
// multiply-fold step and a shared iterative remainder unit.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | dir | beat when
//  ---------+------------------------------------------+-----+---------------------
//  request  | i_in_valid o_in_ready i_cmd i_range_*    | in  | valid && ready
//  result   | o_out_valid i_out_ready o_value          | out | valid && ready
//  seed     | i_cfg_we i_cfg_wdata                     | in  | write enable high
//
//  Raw request and wide full-range request: S_SETUP, S_MUL, S_STEP, then
//  S_DONE until the result register is free. Span below 2^20: S_MOD follows
//  S_STEP and waits on the remainder unit. Masked span: each rejected draw goes
//  from S_STEP back to S_MUL. A seed write folds the seed in the remainder
//  unit; requests wait meanwhile. Reset sets the state to 1 and empties the
//  result register. The result register holds a finished beat while the next request is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lehmer_rng_ranged_defines.svh"

module lehmer_rng_ranged
    import lrr_pkg::*;
#(
    parameter int unsigned MAX_VALUE = 2147483646
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_range_low,
    input  logic [31:0] i_range_high,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_value
);

    localparam logic [31:0] MaxW = 32'(MAX_VALUE);

    t_state r_state, n_state;
    t_mode  r_mode;

    logic [STATE_W-1:0] r_gen;
    logic               r_seed_zero;
    logic [31:0]        r_low;
    logic [31:0]        r_high_c;
    logic               r_zero;
    logic               r_raw;
    logic               r_bool;
    logic [31:0]        r_limit;
    logic [31:0]        r_span;
    logic [31:0]        r_mask;
    logic [31:0]        r_result;
    logic               r_out_valid;
    logic [31:0]        r_out_value;

    logic [STATE_W-1:0] step_next;
    t_rem_req           rem_req;
    t_rem_rsp           rem_rsp;

    logic               in_fire;
    logic               out_load;
    logic               step_load;
    logic [31:0]        eff_low;
    logic [31:0]        eff_high;
    logic [31:0]        setup_limit;
    logic [31:0]        setup_span;
    logic [31:0]        setup_mask;
    logic [31:0]        masked;
    logic               mask_fits;

    // Shared arithmetic units
    lrr_step u_step (
        .i_clk  (i_clk),
        .i_load (step_load),
        .i_x    (r_gen),
        .o_next (step_next)
    );

    lrr_rem_unit u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_rsp   (rem_rsp)
    );

    // Pick the bounds that a request works on
    always_comb begin
        case (i_cmd)
            CMD_BOOL: begin
                eff_low  = BOOL_LOW;
                eff_high = BOOL_HIGH;
            end
            CMD_RAW: begin
                eff_low  = '0;
                eff_high = '0;
            end
            default: begin
                eff_low  = i_range_low;
                eff_high = i_range_high;
            end
        endcase
    end

    // Span, limit and covering mask from the registered bounds
    always_comb begin
        setup_limit = r_high_c - r_low;
        setup_span  = r_high_c - r_low + 32'd1;
        setup_mask  = setup_limit;
        setup_mask  = setup_mask | (setup_mask >> 1);
        setup_mask  = setup_mask | (setup_mask >> 2);
        setup_mask  = setup_mask | (setup_mask >> 4);
        setup_mask  = setup_mask | (setup_mask >> 8);
        setup_mask  = setup_mask | (setup_mask >> 16);
    end

    // Masked draw test
    always_comb begin
        masked    = {1'b0, step_next} & r_mask;
        mask_fits = masked <= r_limit;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        if (i_cfg_we) begin
            n_state = S_FOLD;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) n_state = S_SETUP;
                end
                S_FOLD: begin
                    if (rem_rsp.done) n_state = S_IDLE;
                end
                S_SETUP: begin
                    n_state = r_zero ? S_DONE : S_MUL;
                end
                S_MUL: begin
                    n_state = S_STEP;
                end
                S_STEP: begin
                    case (r_mode)
                        M_FULL:  n_state = S_DONE;
                        M_SMALL: n_state = S_MOD;
                        default: n_state = mask_fits ? S_DONE : S_MUL;
                    endcase
                end
                S_MOD: begin
                    if (rem_rsp.done) n_state = S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) n_state = S_IDLE;
                end
                default: n_state = S_IDLE;
            endcase
        end
    end

    // Sequencer outputs
    always_comb begin
        o_in_ready = (r_state == S_IDLE) && !i_cfg_we;
        in_fire    = o_in_ready && i_in_valid;
        step_load  = (r_state == S_MUL);
        out_load   = (r_state == S_DONE) && !i_cfg_we && (!r_out_valid || i_out_ready);
        rem_req.start    = i_cfg_we || ((r_state == S_STEP) && (r_mode == M_SMALL));
        rem_req.dividend = i_cfg_wdata - 32'd1;
        rem_req.divisor  = MaxW;
        if (!i_cfg_we) begin
            rem_req.dividend = {1'b0, step_next};
            rem_req.divisor  = r_span;
        end
    end

    // State register and generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gen   <= STATE_W'(1);
        end else begin
            r_state <= n_state;
            if (!i_cfg_we && r_state == S_FOLD && rem_rsp.done) begin
                r_gen <= r_seed_zero ? STATE_W'(1) : rem_rsp.rem[STATE_W-1:0] + STATE_W'(1);
            end else if (!i_cfg_we && r_state == S_STEP) begin
                r_gen <= step_next;
            end
        end
    end

    // Request payload and working registers
    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            r_seed_zero <= (i_cfg_wdata == '0);
        end
        if (in_fire) begin
            r_low    <= eff_low;
            r_high_c <= (eff_high > MaxW) ? MaxW : eff_high;
            r_zero   <= (i_cmd == CMD_NONE) || ((i_cmd != CMD_RAW) && (eff_low > eff_high));
            r_raw    <= (i_cmd == CMD_RAW);
            r_bool   <= (i_cmd == CMD_BOOL);
        end
        case (r_state)
            S_SETUP: begin
                r_limit  <= setup_limit;
                r_span   <= setup_span;
                r_mask   <= setup_mask;
                r_result <= '0;
                if (r_raw || setup_limit == '1) begin
                    r_mode <= M_FULL;
                end else if (setup_limit[31:SMALL_SPAN_BITS] == '0 &&
                             setup_limit[SMALL_SPAN_BITS-1:0] != '1) begin
                    r_mode <= M_SMALL;
                end else begin
                    r_mode <= M_MASK;
                end
            end
            S_STEP: begin
                if (r_mode == M_FULL) begin
                    r_result <= r_low + {1'b0, step_next};
                end else begin
                    r_result <= r_low + masked;
                end
            end
            S_MOD: begin
                if (rem_rsp.done) begin
                    r_result <= r_low + rem_rsp.rem;
                end
            end
            default: begin
            end
        endcase
    end

    // Result register: hold a beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value <= r_bool ? {31'd0, (r_result <= BOOL_CUT)} : r_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;

    `LRR_ASSERT_NOW(a_gen_nonzero, i_clk, i_rst_n, 1'b1, r_gen != '0, "generator state is zero")
    `LRR_ASSERT_NEXT(a_bool_bit, i_clk, i_rst_n, out_load && r_bool, o_value <= 32'd1, "boolean result not 0 or 1")
    `LRR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_fire, !o_in_ready, "ready right after accept")

endmodule
